[rtl/core/rgbhr_pkg.sv]
// Shared types, constants and fixed-point helpers for the RGB hue rotation pipeline.
package rgbhr_pkg;

  // Q16 fraction in the range 0..1.0 (1.0 = 65536 needs 17 bits)
  localparam int unsigned QW = 17;

  // Pipelined restoring divider: quotient bits and divisor width
  localparam int unsigned DIV_QW = 17;
  localparam int unsigned DIV_DW = 18;

  localparam logic [QW-1:0] Q_HALF = 17'd32768;

  // floor(x / 6) == (x * DIV6_RECIP) >> DIV6_SHIFT for x < 2^19
  localparam logic [18:0] DIV6_RECIP = 19'd349526;
  localparam int unsigned DIV6_SHIFT = 21;

  typedef logic [QW-1:0] q_t;

  typedef enum logic [2:0] {
    SEXT_RED_YEL = 3'd0,
    SEXT_YEL_GRN = 3'd1,
    SEXT_GRN_CYN = 3'd2,
    SEXT_CYN_BLU = 3'd3,
    SEXT_BLU_MAG = 3'd4,
    SEXT_MAG_RED = 3'd5
  } sext_e;

  // Raw pixel and shift, carried along the whole pipe
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] shift;
  } pass_t;

  // Beside the forward divide
  typedef struct packed {
    pass_t      px;
    logic [2:0] base;   // hue base in sextants
    logic       neg;    // subtract the quotient from the base
    q_t         l;
    logic       black;
    logic       grey;
  } fwd_side_t;

  // Beside the reverse divide
  typedef struct packed {
    pass_t       px;
    q_t          v;
    q_t          m;
    q_t          l;
    sext_e       sext;
    logic [15:0] frac;
  } rev_side_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_out_t;

  // 8-bit code to Q16: x * 65536 / 255 == x * 257 + (x == 255)
  function automatic q_t code_to_q(input logic [7:0] x);
    return {1'b0, x, x} + q_t'(x == 8'hff);
  endfunction

  // Q16 to 8-bit code, round to nearest, saturate at 255
  function automatic logic [7:0] q_to_code(input logic [17:0] q);
    logic [26:0] t;
    t = {1'b0, q, 8'h00} - {9'h000, q} + 27'd32768;
    return (t[26:16] > 11'd255) ? 8'hff : t[23:16];
  endfunction

endpackage

[rtl/core/rgb_hue_rotate_unit.sv]
// Top level of the RGB hue rotation pipeline: RGB to HSL, hue shift, HSL to RGB.
//
// Takes one RGBA beat per clock and returns one RGBA beat per input beat, in
// order. The RGB part goes to 8-bit HSL in Q16 fixed point, hue_shift is added
// to the hue modulo 256, and the color is rebuilt through the six hue
// sextants; alpha passes through. A zero shift returns the pixel untouched.
// Throughput is one beat per cycle while in_stall_o is low; the pipe depth is
// set mostly by the two 17-stage restoring divide passes (saturation and hue
// ratio side by side on the way in, chroma ratio on the way back). A
// two-entry output (output register plus skid register) keeps the pipe
// moving while a finished beat waits; in_stall_o rises only once the skid
// register is full.
module rgb_hue_rotate_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] red_in_i,
  input  logic [7:0] green_in_i,
  input  logic [7:0] blue_in_i,
  input  logic [7:0] alpha_in_i,
  input  logic [7:0] hue_shift_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_out_o,
  output logic [7:0] green_out_o,
  output logic [7:0] blue_out_o,
  output logic [7:0] alpha_out_o
);
  import rgbhr_pkg::*;

  // Whole pipe advances unless the skid register holds a beat
  logic en;
  logic skid_valid_q;
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // ---------------- stage A: channel codes to Q16
  logic  a_v_q;
  pass_t a_px_q;
  q_t    a_r_q, a_g_q, a_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_px_q <= '{red: red_in_i, green: green_in_i, blue: blue_in_i,
                  alpha: alpha_in_i, shift: hue_shift_i};
      a_r_q  <= code_to_q(red_in_i);
      a_g_q  <= code_to_q(green_in_i);
      a_b_q  <= code_to_q(blue_in_i);
    end
  end

  // ---------------- stage B: max/min, lightness, divide operands
  q_t          b_vmax, b_vmin, b_d, b_l, b_x;
  logic [17:0] b_sum, b_den;
  logic [2:0]  b_base;
  logic        b_neg;

  always_comb begin
    b_vmax = (a_r_q > a_g_q) ? a_r_q : a_g_q;
    b_vmax = (b_vmax > a_b_q) ? b_vmax : a_b_q;
    b_vmin = (a_r_q < a_g_q) ? a_r_q : a_g_q;
    b_vmin = (b_vmin < a_b_q) ? b_vmin : a_b_q;
    b_sum  = {1'b0, b_vmax} + {1'b0, b_vmin};
    b_l    = b_sum[17:1];
    b_d    = b_vmax - b_vmin;
    b_den  = (b_l <= Q_HALF) ? b_sum : (18'd131072 - b_sum);
    if (b_den == '0) begin
      b_den = 18'd1;
    end
    // hue sextant base and which channel feeds the ratio
    if (a_r_q == b_vmax) begin
      if (a_g_q == b_vmin) begin
        b_base = 3'd5; b_neg = 1'b0; b_x = a_b_q;
      end else begin
        b_base = 3'd1; b_neg = 1'b1; b_x = a_g_q;
      end
    end else if (a_g_q == b_vmax) begin
      if (a_b_q == b_vmin) begin
        b_base = 3'd1; b_neg = 1'b0; b_x = a_r_q;
      end else begin
        b_base = 3'd3; b_neg = 1'b1; b_x = a_b_q;
      end
    end else begin
      if (a_r_q == b_vmin) begin
        b_base = 3'd3; b_neg = 1'b0; b_x = a_g_q;
      end else begin
        b_base = 3'd5; b_neg = 1'b1; b_x = a_r_q;
      end
    end
  end

  logic              b_v_q;
  fwd_side_t         b_side_q;
  q_t                b_d_q, b_hnum_q;
  logic [DIV_DW-1:0] b_den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_side_q <= '{px: a_px_q, base: b_base, neg: b_neg, l: b_l,
                    black: (b_l == '0), grey: (b_d == '0)};
      b_d_q    <= b_d;
      b_den_q  <= b_den;
      b_hnum_q <= b_vmax - b_x;
    end
  end

  // ---------------- forward divides: saturation and hue ratio
  q_t s_quo, h_quo;

  rgbhr_div u_div_sat (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (b_d_q),
    .den_i (b_den_q),
    .quo_o (s_quo)
  );

  rgbhr_div u_div_hue (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (b_hnum_q),
    .den_i ({1'b0, b_d_q}),
    .quo_o (h_quo)
  );

  logic      fv_q    [DIV_QW];
  fwd_side_t fside_q [DIV_QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      fside_q[0] <= b_side_q;
      for (int k = 1; k < DIV_QW; k++) begin
        fside_q[k] <= fside_q[k-1];
      end
    end
  end

  fwd_side_t fo;
  assign fo = fside_q[DIV_QW-1];

  // ---------------- stage C: hue in sextants, S and L codes
  logic [18:0] c_hfull;
  assign c_hfull = fo.neg ? ({fo.base, 16'h0000} - {2'b00, h_quo})
                          : ({fo.base, 16'h0000} + {2'b00, h_quo});

  logic        c_v_q;
  pass_t       c_px_q;
  logic [18:0] c_h_q;
  logic [7:0]  c_sc_q, c_lc_q;
  logic        c_hz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_px_q <= fo.px;
      c_h_q  <= c_hfull;
      c_hz_q <= fo.black | fo.grey;
      c_sc_q <= (fo.black | fo.grey) ? 8'h00 : q_to_code(18'(s_quo));
      c_lc_q <= fo.black ? 8'h00 : q_to_code(18'(fo.l));
    end
  end

  // ---------------- stage D: divide hue by six
  logic [37:0] d_prod;
  assign d_prod = 38'(c_h_q) * 38'(DIV6_RECIP);

  logic       d_v_q;
  pass_t      d_px_q;
  q_t         d_h_q;
  logic [7:0] d_sc_q, d_lc_q;
  logic       d_hz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_px_q <= c_px_q;
      d_h_q  <= d_prod[37:DIV6_SHIFT];
      d_hz_q <= c_hz_q;
      d_sc_q <= c_sc_q;
      d_lc_q <= c_lc_q;
    end
  end

  // ---------------- stage E: hue code plus shift
  logic [7:0] e_hc;
  assign e_hc = d_hz_q ? 8'h00 : q_to_code(18'(d_h_q));

  logic       e_v_q;
  pass_t      e_px_q;
  logic [7:0] e_hc_q, e_sc_q, e_lc_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_px_q <= d_px_q;
      e_hc_q <= e_hc + d_px_q.shift;
      e_sc_q <= d_sc_q;
      e_lc_q <= d_lc_q;
    end
  end

  // ---------------- stage F: HSL codes back to Q16
  logic  f_v_q;
  pass_t f_px_q;
  q_t    f_h_q, f_s_q, f_l_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_px_q <= e_px_q;
      f_h_q  <= code_to_q(e_hc_q);
      f_s_q  <= code_to_q(e_sc_q);
      f_l_q  <= code_to_q(e_lc_q);
    end
  end

  // ---------------- stage G: lightness product, 6h
  logic        g_low;
  logic [17:0] g_op;
  assign g_low = (f_l_q <= Q_HALF);
  assign g_op  = g_low ? (18'd65536 + 18'(f_s_q)) : 18'(f_s_q);

  logic        g_v_q;
  pass_t       g_px_q;
  logic [34:0] g_prod_q;
  logic        g_low_q;
  q_t          g_l_q, g_s_q;
  logic [18:0] g_h6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_px_q   <= f_px_q;
      g_prod_q <= 35'(f_l_q) * 35'(g_op);
      g_low_q  <= g_low;
      g_l_q    <= f_l_q;
      g_s_q    <= f_s_q;
      g_h6_q   <= (19'(f_h_q) << 2) + (19'(f_h_q) << 1);
    end
  end

  // ---------------- stage H: top value v, sextant and fraction
  logic [18:0] h_v19;
  sext_e       h_sext;
  assign h_v19  = g_low_q ? g_prod_q[34:16]
                          : (19'(g_l_q) + 19'(g_s_q) - g_prod_q[34:16]);
  // a full turn (six sextants) wraps to the first
  assign h_sext = (g_h6_q[18:16] == 3'd6) ? SEXT_RED_YEL : sext_e'(g_h6_q[18:16]);

  logic        h_v_q;
  pass_t       h_px_q;
  q_t          h_top_q, h_l_q;
  sext_e       h_sext_q;
  logic [15:0] h_frac_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_px_q   <= g_px_q;
      h_top_q  <= h_v19[16:0];
      h_l_q    <= g_l_q;
      h_sext_q <= h_sext;
      h_frac_q <= g_h6_q[15:0];
    end
  end

  // ---------------- stage I: bottom value m = 2l - v, clamped to 0..v
  logic signed [18:0] i_ms;
  q_t                 i_m;
  assign i_ms = $signed({1'b0, h_l_q, 1'b0}) - $signed({2'b00, h_top_q});

  always_comb begin
    if (i_ms < 0) begin
      i_m = '0;
    end else if (i_ms[17:0] > {1'b0, h_top_q}) begin
      i_m = h_top_q;
    end else begin
      i_m = i_ms[16:0];
    end
  end

  logic      i_v_q;
  rev_side_t i_side_q;
  q_t        i_diff_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_side_q <= '{px: h_px_q, v: h_top_q, m: i_m, l: h_l_q,
                    sext: h_sext_q, frac: h_frac_q};
      i_diff_q <= h_top_q - i_m;
    end
  end

  // ---------------- reverse divide: chroma over v
  q_t sv_quo;

  rgbhr_div u_div_sv (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (i_diff_q),
    .den_i ({1'b0, i_side_q.v}),
    .quo_o (sv_quo)
  );

  logic      rv_q    [DIV_QW];
  rev_side_t rside_q [DIV_QW];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rside_q[0] <= i_side_q;
      for (int k = 1; k < DIV_QW; k++) begin
        rside_q[k] <= rside_q[k-1];
      end
    end
  end

  // ---------------- stage J: v * sv
  logic [33:0] j_prod;
  assign j_prod = 34'(rside_q[DIV_QW-1].v) * 34'(sv_quo);

  logic      j_v_q;
  rev_side_t j_side_q;
  q_t        j_vs_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      j_side_q <= rside_q[DIV_QW-1];
      j_vs_q   <= j_prod[32:16];
    end
  end

  // ---------------- stage K: times the sextant fraction
  logic [32:0] k_prod;
  assign k_prod = 33'(j_vs_q) * 33'(j_side_q.frac);

  logic      k_v_q;
  rev_side_t k_side_q;
  q_t        k_vsf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k_side_q <= j_side_q;
      k_vsf_q  <= k_prod[32:16];
    end
  end

  // ---------------- stage L: pick channel values by sextant
  logic [17:0] l_mid1, l_mid2, l_vx, l_mx, l_r, l_g, l_b;

  always_comb begin
    l_vx   = 18'(k_side_q.v);
    l_mx   = 18'(k_side_q.m);
    l_mid1 = l_mx + 18'(k_vsf_q);
    l_mid2 = l_vx - 18'(k_vsf_q);
    case (k_side_q.sext)
      SEXT_RED_YEL: begin l_r = l_vx;   l_g = l_mid1; l_b = l_mx;   end
      SEXT_YEL_GRN: begin l_r = l_mid2; l_g = l_vx;   l_b = l_mx;   end
      SEXT_GRN_CYN: begin l_r = l_mx;   l_g = l_vx;   l_b = l_mid1; end
      SEXT_CYN_BLU: begin l_r = l_mx;   l_g = l_mid2; l_b = l_vx;   end
      SEXT_BLU_MAG: begin l_r = l_mid1; l_g = l_mx;   l_b = l_vx;   end
      default:      begin l_r = l_vx;   l_g = l_mx;   l_b = l_mid2; end
    endcase
    // v of zero: all channels equal lightness
    if (k_side_q.v == '0) begin
      l_r = 18'(k_side_q.l);
      l_g = 18'(k_side_q.l);
      l_b = 18'(k_side_q.l);
    end
  end

  logic        l_v_q;
  pass_t       l_px_q;
  logic [17:0] l_r_q, l_g_q, l_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      l_px_q <= k_side_q.px;
      l_r_q  <= l_r;
      l_g_q  <= l_g;
      l_b_q  <= l_b;
    end
  end

  // ---------------- stage M: back to codes, zero-shift bypass
  logic     m_v_q;
  pix_out_t m_out_q;
  logic     bypass;
  assign bypass = (l_px_q.shift == 8'h00);

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_out_q.red   <= bypass ? l_px_q.red   : q_to_code(l_r_q);
      m_out_q.green <= bypass ? l_px_q.green : q_to_code(l_g_q);
      m_out_q.blue  <= bypass ? l_px_q.blue  : q_to_code(l_b_q);
      m_out_q.alpha <= l_px_q.alpha;
    end
  end

  // ---------------- valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
      g_v_q <= 1'b0;
      h_v_q <= 1'b0;
      i_v_q <= 1'b0;
      j_v_q <= 1'b0;
      k_v_q <= 1'b0;
      l_v_q <= 1'b0;
      m_v_q <= 1'b0;
      for (int k = 0; k < DIV_QW; k++) begin
        fv_q[k] <= 1'b0;
        rv_q[k] <= 1'b0;
      end
    end else if (en) begin
      a_v_q   <= in_valid_i;
      b_v_q   <= a_v_q;
      fv_q[0] <= b_v_q;
      rv_q[0] <= i_v_q;
      for (int k = 1; k < DIV_QW; k++) begin
        fv_q[k] <= fv_q[k-1];
        rv_q[k] <= rv_q[k-1];
      end
      c_v_q <= fv_q[DIV_QW-1];
      d_v_q <= c_v_q;
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
      g_v_q <= f_v_q;
      h_v_q <= g_v_q;
      i_v_q <= h_v_q;
      j_v_q <= rv_q[DIV_QW-1];
      k_v_q <= j_v_q;
      l_v_q <= k_v_q;
      m_v_q <= l_v_q;
    end
  end

  // ---------------- output register and skid register
  logic     leave;
  logic     out_free;
  logic     out_valid_q;
  pix_out_t out_q, skid_q;

  assign leave    = m_v_q && en;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= leave;
      end
    end else if (leave) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : m_out_q;
    end else if (leave) begin
      skid_q <= m_out_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q.red;
  assign green_out_o = out_q.green;
  assign blue_out_o  = out_q.blue;
  assign alpha_out_o = out_q.alpha;

endmodule

[rtl/core/rgbhr_div.sv]
// Pipelined restoring divider: quo = (num << 16) / den, one quotient bit per stage.
module rgbhr_div (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  rgbhr_pkg::q_t                    num_i,
  input  logic [rgbhr_pkg::DIV_DW-1:0]     den_i,
  output rgbhr_pkg::q_t                    quo_o
);
  import rgbhr_pkg::*;

  localparam int unsigned RW  = DIV_QW + 17;
  localparam int unsigned RWX = RW + 1;

  logic [RW-1:0]     rem_q [DIV_QW];
  logic [DIV_DW-1:0] den_q [DIV_QW];
  q_t                quo_q [DIV_QW];

  for (genvar k = 0; k < DIV_QW; k++) begin : g_step
    logic [RW-1:0]     rem_in;
    logic [DIV_DW-1:0] den_in;
    q_t                quo_in;
    logic [RWX-1:0]    trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign rem_in = {1'b0, num_i, 16'h0000};
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = RWX'(den_in) << (DIV_QW - 1 - k);
    assign fits  = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? (rem_in - trial[RW-1:0]) : rem_in;
        den_q[k] <= den_in;
        quo_q[k] <= quo_in | (fits ? (q_t'(1) << (DIV_QW - 1 - k)) : '0);
      end
    end
  end

  assign quo_o = quo_q[DIV_QW-1];

endmodule
